// ===== rtl/command_line_tokenizer_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the command-line tokenizer
// Clocked, reset-gated implication checks used by the RTL modules.
// ----------------------------------------------------------------------------
`ifndef COMMAND_LINE_TOKENIZER_MACROS_SVH
`define COMMAND_LINE_TOKENIZER_MACROS_SVH

// same-cycle implication
`define CLT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tokenizer check failed");

// next-cycle implication
`define CLT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tokenizer check failed");

`endif

// ===== rtl/clt_pkg.sv =====
// ----------------------------------------------------------------------------
// clt_pkg
// Types and constants shared by the command-line tokenizer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package clt_pkg;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [7:0] C_PIPE  = 8'h7C;
    localparam logic [7:0] C_AMP   = 8'h26;
    localparam logic [7:0] C_GT    = 8'h3E;
    localparam logic [7:0] C_LT    = 8'h3C;
    localparam logic [7:0] C_TWO   = 8'h32;
    localparam logic [7:0] C_QUOTE = 8'h22;
    localparam logic [7:0] C_TAB   = 8'h09;
    localparam logic [7:0] C_SPACE = 8'h20;
    localparam logic [7:0] C_LF    = 8'h0A;
    localparam logic [7:0] C_CR    = 8'h0D;

    typedef enum logic [2:0] {
        K_BYTE    = 3'd0,
        K_WEND    = 3'd1,
        K_PIPE    = 3'd2,
        K_BG      = 3'd3,
        K_OK      = 3'd4,
        K_OK_TAIL = 3'd5,
        K_EMPTY   = 3'd6
    } t_kind;

    typedef enum logic [2:0] {
        R_ARG    = 3'd0,
        R_STDIN  = 3'd1,
        R_STDOUT = 3'd2,
        R_APPEND = 3'd3,
        R_STDERR = 3'd4
    } t_role;

    typedef enum logic [2:0] {
        S_IDLE   = 3'd0,
        S_PGT    = 3'd1,
        S_PTWO   = 3'd2,
        S_TARGET = 3'd3,
        S_UNQ    = 3'd4,
        S_QUOTED = 3'd5
    } t_scan;

    typedef struct packed {
        t_kind       kind;
        t_role       role;
        logic [7:0]  data;
    } t_res;

    // up to three results caused by one input transfer
    typedef struct packed {
        logic [1:0]       count;
        t_res [2:0]       res;
    } t_bundle;

    function automatic logic is_space(input logic [7:0] c);
        return (c == C_SPACE) || (c == C_TAB) || (c == C_LF) || (c == C_CR);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/command_line_tokenizer.sv =====
// Path: an accepted byte's result bundle is pushed into the bundle queue, and its results
// are loaded one at a time from the queue head into the registered output.
// Throughput: one input byte per cycle while the queue is not full; results leave one
// per cycle while the sink is ready, and a 4-bundle queue absorbs bursts.
// Reset: synchronous, active low; clears the scan state, queue pointers and output valid flag.
// ----------------------------------------------------------------------------
// command_line_tokenizer
// Splits a command-line byte stream into word bytes, tagged word ends,
// separators and an end-of-line verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module command_line_tokenizer
    import clt_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_tvalid,
    output logic            o_s_tready,
    input  wire logic [7:0] i_s_tdata,   // [7:0] ch
    input  wire logic       i_s_tlast,   // end_of_line
    output logic            o_m_tvalid,
    input  wire logic       i_m_tready,
    output logic [7:0]      o_m_tdata,   // [7:0] byte_res
    output logic [5:0]      o_m_tuser,   // [2:0] kind, [5:3] role
    output logic            o_m_tlast    // last
);

    logic    push;
    logic    full;
    logic    q_valid;
    logic    pop;
    t_bundle push_data;
    t_bundle head;
    t_res    res;

    clt_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_tvalid),
        .i_ch     (i_s_tdata),
        .i_eol    (i_s_tlast),
        .o_ready  (o_s_tready),
        .o_push   (push),
        .o_bundle (push_data),
        .i_full   (full)
    );

    clt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .o_full  (full),
        .o_valid (q_valid),
        .o_data  (head),
        .i_pop   (pop)
    );

    clt_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_data  (head),
        .o_pop   (pop),
        .o_valid (o_m_tvalid),
        .o_res   (res),
        .o_last  (o_m_tlast),
        .i_ready (i_m_tready)
    );

    assign o_m_tdata = res.data;
    assign o_m_tuser = {res.role, res.kind};

endmodule

`default_nettype wire

// ===== rtl/clt_queue.sv =====
// ----------------------------------------------------------------------------
// clt_queue
// Short FIFO of result bundles between the scanner and the output stage.
// ----------------------------------------------------------------------------
`default_nettype none
`include "command_line_tokenizer_macros.svh"

module clt_queue
    import clt_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_bundle i_data,
    output logic         o_full,
    output logic         o_valid,
    output t_bundle      o_data,
    input  wire logic    i_pop
);

    t_bundle             r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wr, n_wr;
    logic [QPTR_W-1:0]   r_rd, n_rd;
    logic [QCNT_W-1:0]   r_count, n_count;
    logic                push;
    logic                pop;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    assign push    = i_push && !o_full;
    assign pop     = i_pop && o_valid;

    always_comb begin
        n_wr    = push ? r_wr + 1'b1 : r_wr;
        n_rd    = pop ? r_rd + 1'b1 : r_rd;
        n_count = r_count + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    `CLT_ASSERT_NOW(a_q_bound, i_clk, i_rst_n, 1'b1, r_count <= QCNT_W'(QDEPTH))
    `CLT_ASSERT_NOW(a_q_no_overrun, i_clk, i_rst_n, i_push && !pop && o_full, !push)

endmodule

`default_nettype wire

// ===== rtl/clt_front.sv =====
// ----------------------------------------------------------------------------
// clt_front
// Scanner: accepts input bytes, tracks token state, builds result bundles.
// ----------------------------------------------------------------------------
`default_nettype none
`include "command_line_tokenizer_macros.svh"

module clt_front
    import clt_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [7:0] i_ch,
    input  wire logic       i_eol,
    output logic            o_ready,
    output logic            o_push,
    output t_bundle         o_bundle,
    input  wire logic       i_full
);

    t_scan   r_state, n_state;
    t_role   r_role, n_role;
    logic    r_has_arg, n_has_arg;
    logic    r_has_pred, n_has_pred;
    logic    accept;
    t_bundle b;

    function automatic t_bundle put(input t_bundle bi, input t_kind k, input t_role r,
                                    input logic [7:0] d);
        t_bundle bo;
        bo                   = bi;
        bo.res[bi.count].kind = k;
        bo.res[bi.count].role = r;
        bo.res[bi.count].data = d;
        bo.count             = bi.count + 2'd1;
        return bo;
    endfunction

    assign o_ready  = !i_full;
    assign accept   = i_valid && o_ready;
    assign o_push   = accept && (b.count != 2'd0);
    assign o_bundle = b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_role     <= R_ARG;
            r_has_arg  <= 1'b0;
            r_has_pred <= 1'b0;
        end else if (accept) begin
            r_state    <= n_state;
            r_role     <= n_role;
            r_has_arg  <= n_has_arg;
            r_has_pred <= n_has_pred;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_role     = r_role;
        n_has_arg  = r_has_arg;
        n_has_pred = r_has_pred;
        b          = '0;
        if (i_eol) begin
            unique case (r_state)
                S_PGT: begin
                    b = put(b, K_WEND, R_STDOUT, 8'h00);
                end
                S_PTWO: begin
                    b         = put(b, K_BYTE, R_ARG, C_TWO);
                    b         = put(b, K_WEND, R_ARG, 8'h00);
                    n_has_arg = 1'b1;
                end
                S_TARGET, S_UNQ, S_QUOTED: begin
                    b = put(b, K_WEND, r_role, 8'h00);
                    if (r_role == R_ARG) begin
                        n_has_arg = 1'b1;
                    end
                end
                default: ;
            endcase
            if (n_has_arg) begin
                b = put(b, K_OK, R_ARG, 8'h00);
            end else if (r_has_pred) begin
                b = put(b, K_OK_TAIL, R_ARG, 8'h00);
            end else begin
                b = put(b, K_EMPTY, R_ARG, 8'h00);
            end
            n_state    = S_IDLE;
            n_role     = R_ARG;
            n_has_arg  = 1'b0;
            n_has_pred = 1'b0;
        end else begin
            unique case (r_state)
                S_PGT: begin
                    n_state = S_TARGET;
                    if (i_ch == C_GT) begin
                        n_role = R_APPEND;
                    end else begin
                        n_role = R_STDOUT;
                        if (i_ch == C_QUOTE) begin
                            n_state = S_QUOTED;
                        end else if (!is_space(i_ch)) begin
                            n_state = S_UNQ;
                            b       = put(b, K_BYTE, R_STDOUT, i_ch);
                        end
                    end
                end
                S_PTWO: begin
                    if (i_ch == C_GT) begin
                        n_role  = R_STDERR;
                        n_state = S_TARGET;
                    end else begin
                        n_role = R_ARG;
                        b      = put(b, K_BYTE, R_ARG, C_TWO);
                        if (is_space(i_ch)) begin
                            b         = put(b, K_WEND, R_ARG, 8'h00);
                            n_has_arg = 1'b1;
                            n_state   = S_IDLE;
                        end else begin
                            b       = put(b, K_BYTE, R_ARG, i_ch);
                            n_state = S_UNQ;
                        end
                    end
                end
                S_TARGET: begin
                    if (i_ch == C_QUOTE) begin
                        n_state = S_QUOTED;
                    end else if (!is_space(i_ch)) begin
                        n_state = S_UNQ;
                        b       = put(b, K_BYTE, r_role, i_ch);
                    end
                end
                S_UNQ, S_QUOTED: begin
                    if ((r_state == S_UNQ && is_space(i_ch)) ||
                        (r_state == S_QUOTED && i_ch == C_QUOTE)) begin
                        b = put(b, K_WEND, r_role, 8'h00);
                        if (r_role == R_ARG) begin
                            n_has_arg = 1'b1;
                        end
                        n_role  = R_ARG;
                        n_state = S_IDLE;
                    end else begin
                        b = put(b, K_BYTE, r_role, i_ch);
                    end
                end
                default: begin
                    n_state = S_IDLE;
                    if (i_ch == C_PIPE || i_ch == C_AMP) begin
                        b          = put(b, (i_ch == C_PIPE) ? K_PIPE : K_BG, R_ARG, 8'h00);
                        n_has_arg  = 1'b0;
                        n_has_pred = 1'b1;
                    end else if (!is_space(i_ch)) begin
                        n_role = R_ARG;
                        if (i_ch == C_GT) begin
                            n_state = S_PGT;
                        end else if (i_ch == C_TWO) begin
                            n_state = S_PTWO;
                        end else if (i_ch == C_LT) begin
                            n_role  = R_STDIN;
                            n_state = S_TARGET;
                        end else if (i_ch == C_QUOTE) begin
                            n_state = S_QUOTED;
                        end else begin
                            n_state = S_UNQ;
                            b       = put(b, K_BYTE, R_ARG, i_ch);
                        end
                    end
                end
            endcase
        end
    end

    `CLT_ASSERT_NEXT(a_eol_clears, i_clk, i_rst_n, accept && i_eol,
        r_state == S_IDLE && r_role == R_ARG && !r_has_arg && !r_has_pred)
    `CLT_ASSERT_NOW(a_eol_pushes, i_clk, i_rst_n, accept && i_eol, o_push)

endmodule

`default_nettype wire

// ===== rtl/clt_back.sv =====
// ----------------------------------------------------------------------------
// clt_back
// Output stage: unpacks queued bundles into single results, one per transfer.
// ----------------------------------------------------------------------------
`default_nettype none
`include "command_line_tokenizer_macros.svh"

module clt_back
    import clt_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    input  wire t_bundle i_data,
    output logic         o_pop,
    output logic         o_valid,
    output t_res         o_res,
    output logic         o_last,
    input  wire logic    i_ready
);

    logic [1:0] r_idx, n_idx;
    logic       r_valid, n_valid;
    t_res       r_res;
    logic       r_last;
    logic       load;
    logic       pick_last;

    assign load      = i_valid && (!r_valid || i_ready);
    assign pick_last = (r_idx == i_data.count - 2'd1);
    assign o_pop     = load && pick_last;
    assign o_valid   = r_valid;
    assign o_res     = r_res;
    assign o_last    = r_last;

    always_comb begin
        n_idx   = r_idx;
        n_valid = r_valid;
        if (load) begin
            n_idx   = pick_last ? 2'd0 : r_idx + 2'd1;
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res  <= i_data.res[r_idx];
            r_last <= pick_last;
        end
    end

    `CLT_ASSERT_NOW(a_idx_in_bundle, i_clk, i_rst_n, i_valid, r_idx < i_data.count)
    `CLT_ASSERT_NOW(a_idx_zero_idle, i_clk, i_rst_n, !i_valid, r_idx == 2'd0)

endmodule

`default_nettype wire
